@@ rtl/acld_pkg.sv @@
// Package for the ASCII CAN line decoder: character codes, result kinds,
// walk state types and the lax hex digit conversion.
// No dependencies.
package acld_pkg;

  // Control characters and command letters
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_T  = 8'h74;  // 't'
  localparam logic [7:0] CH_UP_T  = 8'h54;  // 'T'
  localparam logic [7:0] CH_LO_R  = 8'h72;  // 'r'
  localparam logic [7:0] CH_UP_R  = 8'h52;  // 'R'
  localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_TEN = 8'd10;

  // Id digit counts for standard and extended frames, and the largest data length
  localparam logic [3:0] STD_ID_DIGITS = 4'd3;
  localparam logic [3:0] EXT_ID_DIGITS = 4'd8;
  localparam logic [3:0] MAX_DLC       = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_BELL  = 2'd2;

  // Line walk sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIGIT,
    ST_PAD,
    ST_EMIT
  } state_t;

  // Field the current character belongs to
  typedef enum logic [1:0] {
    FLD_ID,
    FLD_DLC,
    FLD_HI,
    FLD_LO
  } field_t;

  // Lax hex conversion, wrapping at 8 bits
  function automatic logic [7:0] lax_digit(input logic [7:0] c);
    logic [7:0] r;
    if (c >= CH_LO_A) begin
      r = c - CH_LO_A + DIGIT_TEN;
    end else if (c >= CH_UP_A) begin
      r = c - CH_UP_A + DIGIT_TEN;
    end else begin
      r = c - CH_ZERO;
    end
    return r;
  endfunction

endpackage

@@ rtl/ascii_can_line_decoder_unit.sv @@
// ASCII CAN line decoder top level: line buffer, line walk sequencer and
// output register. Depends on acld_pkg.
//
// Usage: received characters enter one word per accepted cycle on the input
// channel (in_valid / in_stall / rx_byte). Each character but BEL and
// carriage return is stored in a line memory of LINE_CHARS entries; one
// that meets a full line discards the line instead. BEL gives a bell error
// word and a carriage return on an empty line or a line opening with z or
// Z gives a status ok word; both are loaded in the cycle after the character.
// A carriage return on a t, T, r or R line long enough for its id and
// length digits starts a walk over the stored line: the sequencer reads each
// character through the single read port of the line memory (address, then
// registered data), shifts id digits into the identifier and data digit pairs
// into a 64-bit payload shift register that moves a byte at a time, then pads
// the payload with zero bytes, one per cycle, up to eight bytes, and loads the
// frame word into the output register. Lines that do not decode give no word.
// in_stall is high during a walk and while a finished word is held and
// out_stall is high; a stalled output word holds its value. One line is
// worked on at a time. Reset clears the line count, the sequencer and the
// output valid flag; the line memory needs no clearing.
module ascii_can_line_decoder_unit
  import acld_pkg::*;
#(
  parameter int LINE_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic        remote_frame,
  output logic        extended_id,
  output logic [31:0] frame_id,
  output logic [3:0]  data_length,
  output logic [63:0] payload
);

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(LINE_CHARS);

  // Line memory and its registered read data
  logic [7:0]    line_store [LINE_CHARS];
  logic [7:0]    rdata;

  logic [CW-1:0] line_count;
  logic [7:0]    cmd;
  logic [CW-1:0] line_len;
  logic [CW-1:0] pos;
  state_t        state;
  state_t        state_next;
  field_t        field;
  logic          remote;
  logic          ext;
  logic [3:0]    id_left;
  logic [31:0]   id_acc;
  logic [3:0]    dlc;
  logic [3:0]    hi;
  logic [3:0]    k;
  logic [63:0]   pay_sr;

  logic          in_fire;
  logic          is_bel;
  logic          is_cr;
  logic          cmd_z;
  logic          cmd_ok;
  logic          cmd_ext;
  logic          cmd_remote;
  logic [3:0]    id_digits;
  logic          line_short;
  logic          start_walk;
  logic          status_load;
  logic          emit_load;
  logic          out_free;
  logic          line_full;
  logic [7:0]    digit;
  logic          dlc_bad;
  logic [CW-1:0] need_len;
  logic          data_short;
  logic [3:0]    k_inc;
  logic [7:0]    data_byte;

  // Decode the incoming character and the stored command letter
  always_comb begin
    in_fire    = in_valid && !in_stall;
    is_bel     = (rx_byte == CH_BEL);
    is_cr      = (rx_byte == CH_CR);
    cmd_z      = (cmd == CH_LO_Z) || (cmd == CH_UP_Z);
    cmd_ok     = (cmd == CH_LO_T) || (cmd == CH_UP_T) ||
                 (cmd == CH_LO_R) || (cmd == CH_UP_R);
    cmd_ext    = (cmd == CH_UP_T) || (cmd == CH_UP_R);
    cmd_remote = (cmd == CH_LO_R) || (cmd == CH_UP_R);
    id_digits  = cmd_ext ? EXT_ID_DIGITS : STD_ID_DIGITS;
    line_short = (line_count < CW'(id_digits + 4'd2));
    line_full  = (line_count == CW'(LINE_CHARS));
    start_walk = in_fire && is_cr && (line_count != '0) && !cmd_z && cmd_ok &&
                 !line_short;
    status_load = in_fire && (is_bel || (is_cr && ((line_count == '0) || cmd_z)));
  end

  // Digit under the walk
  always_comb begin
    digit      = lax_digit(rdata);
    dlc_bad    = (digit > {4'd0, MAX_DLC});
    need_len   = pos + CW'(1) + CW'({digit[3:0], 1'b0});
    data_short = (line_len < need_len);
    k_inc      = k + 4'd1;
    data_byte  = {hi, 4'd0} + digit;
  end

  // Next state of the walk sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_walk) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        case (field)
          FLD_ID: state_next = ST_FETCH;
          FLD_DLC: begin
            if (dlc_bad) begin
              state_next = ST_IDLE;
            end else if (remote) begin
              state_next = ST_EMIT;
            end else if (data_short) begin
              state_next = ST_IDLE;
            end else if (digit[3:0] == 4'd0) begin
              state_next = ST_PAD;
            end else begin
              state_next = ST_FETCH;
            end
          end
          FLD_HI: state_next = ST_FETCH;
          FLD_LO: begin
            if (k_inc == dlc) begin
              state_next = (k_inc == MAX_DLC) ? ST_EMIT : ST_PAD;
            end else begin
              state_next = ST_FETCH;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        if (k_inc == MAX_DLC) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer
  always_comb begin
    out_free  = !out_valid || !out_stall;
    in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
    emit_load = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store characters; read one entry per cycle at the walk position
  always_ff @(posedge clk) begin
    if (in_fire && !is_bel && !is_cr && !line_full) begin
      line_store[line_count[AW-1:0]] <= rx_byte;
    end
    rdata <= line_store[pos[AW-1:0]];
  end

  // Line count and command letter
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (in_fire) begin
      if (is_bel || is_cr || line_full) begin
        line_count <= '0;
      end else begin
        line_count <= line_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !is_bel && !is_cr && (line_count == '0)) begin
      cmd <= rx_byte;
    end
  end

  // Walk datapath: shift digits into id and payload
  always_ff @(posedge clk) begin
    if (start_walk) begin
      line_len <= line_count;
      pos      <= CW'(1);
      field    <= FLD_ID;
      remote   <= cmd_remote;
      ext      <= cmd_ext;
      id_left  <= id_digits;
      id_acc   <= '0;
      k        <= '0;
      pay_sr   <= '0;
    end else if (state == ST_DIGIT) begin
      pos <= pos + CW'(1);
      case (field)
        FLD_ID: begin
          id_acc  <= {id_acc[27:0], 4'd0} + {24'd0, digit};
          id_left <= id_left - 4'd1;
          if (id_left == 4'd1) field <= FLD_DLC;
        end
        FLD_DLC: begin
          dlc   <= digit[3:0];
          field <= FLD_HI;
        end
        FLD_HI: begin
          hi    <= digit[3:0];
          field <= FLD_LO;
        end
        FLD_LO: begin
          pay_sr <= {data_byte, pay_sr[63:8]};
          k      <= k_inc;
          field  <= FLD_HI;
        end
        default: field <= FLD_ID;
      endcase
    end else if (state == ST_PAD) begin
      pay_sr <= {8'd0, pay_sr[63:8]};
      k      <= k_inc;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status_load || emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status_load) begin
      result_kind  <= is_bel ? KIND_BELL : KIND_OK;
      remote_frame <= 1'b0;
      extended_id  <= 1'b0;
      frame_id     <= '0;
      data_length  <= '0;
      payload      <= '0;
    end else if (emit_load) begin
      result_kind  <= KIND_FRAME;
      remote_frame <= remote;
      extended_id  <= ext;
      frame_id     <= id_acc;
      data_length  <= dlc;
      payload      <= pay_sr;
    end
  end

endmodule

@@ tb/ascii_can_line_decoder_unit_tb.sv @@
// Self-checking testbench for the ASCII CAN line decoder: directed lines, a long output
// hold-off, then random line traffic under varying idle and stall pressure.
// Depends on acld_pkg and ascii_can_line_decoder_unit.
module ascii_can_line_decoder_unit_tb
  import acld_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CHARS  = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 120;

  typedef struct packed {
    logic [1:0]  kind;
    logic        remote;
    logic        ext;
    logic [31:0] id;
    logic [3:0]  dlc;
    logic [63:0] data;
  } can_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic        remote_frame;
  logic        extended_id;
  logic [31:0] frame_id;
  logic [3:0]  data_length;
  logic [63:0] payload;

  // Line tracker and decoded words still due from the block
  logic [7:0] line_chars [LINE_CHARS];
  int         line_len = 0;
  can_word_t  words_due [$];

  int  mismatches = 0;
  int  chars_sent = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  ascii_can_line_decoder_unit #(
    .LINE_CHARS(LINE_CHARS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .remote_frame(remote_frame),
    .extended_id(extended_id),
    .frame_id(frame_id),
    .data_length(data_length),
    .payload(payload)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Lax hex digit value, kept to 8 bits
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c >= CH_LO_A) return c - CH_LO_A + 8'd10;
    if (c >= CH_UP_A) return c - CH_UP_A + 8'd10;
    return c - CH_ZERO;
  endfunction

  // Random hex character, now and then any byte at all
  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(22);
    if (v == 22) return 8'($urandom_range(255));
    if (v < 10) return 8'(CH_ZERO + v);
    if (v < 16) return 8'(CH_UP_A + v - 10);
    return 8'(CH_LO_A + v - 16);
  endfunction

  // Track one accepted character and queue the word it should produce
  task automatic predict_char(input logic [7:0] c);
    can_word_t  w;
    int         len;
    int         n_id;
    int         pos;
    logic [7:0] dlc;
    logic [7:0] hi;
    logic [7:0] lo;
    w = '0;
    if (c == CH_BEL) begin
      line_len = 0;
      w.kind = KIND_BELL;
      words_due = {words_due, w};
      return;
    end
    if (c != CH_CR) begin
      // a character meeting a full line throws the whole line away
      if (line_len >= LINE_CHARS) begin
        line_len = 0;
      end else begin
        line_chars[line_len] = c;
        line_len++;
      end
      return;
    end
    len = line_len;
    line_len = 0;
    if (len == 0 || line_chars[0] == CH_LO_Z || line_chars[0] == CH_UP_Z) begin
      w.kind = KIND_OK;
      words_due = {words_due, w};
      return;
    end
    if (line_chars[0] != CH_LO_T && line_chars[0] != CH_UP_T &&
        line_chars[0] != CH_LO_R && line_chars[0] != CH_UP_R) return;
    w.kind = KIND_FRAME;
    w.remote = (line_chars[0] == CH_LO_R || line_chars[0] == CH_UP_R);
    w.ext = (line_chars[0] == CH_UP_T || line_chars[0] == CH_UP_R);
    n_id = w.ext ? 8 : 3;
    if (len < n_id + 2) return;
    for (pos = 1; pos <= n_id; pos++) begin
      w.id = (w.id << 4) + 32'(hex_value(line_chars[pos]));
    end
    dlc = hex_value(line_chars[pos]);
    pos++;
    if (dlc > 8) return;
    w.dlc = dlc[3:0];
    // remote requests read no data digits
    if (!w.remote) begin
      if (len < pos + 2 * dlc) return;
      for (int k = 0; k < dlc; k++) begin
        hi = hex_value(line_chars[pos + 2 * k]);
        lo = hex_value(line_chars[pos + 2 * k + 1]);
        w.data[8 * k +: 8] = {hi[3:0], 4'h0} + lo;
      end
    end
    words_due = {words_due, w};
  endtask

  // Offer one character, idling first at random, and hold it until accepted
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    predict_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_char(CH_CR);
  endtask

  // Mostly well-formed lines with random content, the rest status, bell and junk
  task automatic send_random_line();
    int         shape;
    int         n_id;
    int         dlc;
    logic [7:0] cmd;
    shape = $urandom_range(99);
    case ($urandom_range(3))
      0:       cmd = CH_LO_T;
      1:       cmd = CH_UP_T;
      2:       cmd = CH_LO_R;
      default: cmd = CH_UP_R;
    endcase
    n_id = (cmd == CH_UP_T || cmd == CH_UP_R) ? 8 : 3;
    if (shape < 70) begin
      dlc = $urandom_range(8);
      send_char(cmd);
      repeat (n_id) send_char(rand_hex());
      send_char(8'(CH_ZERO + dlc));
      if (cmd == CH_LO_T || cmd == CH_UP_T || $urandom_range(3) == 0) begin
        repeat (2 * dlc) send_char(rand_hex());
      end
      if ($urandom_range(9) == 0) repeat ($urandom_range(4)) send_char(rand_hex());
      send_char(CH_CR);
    end else if (shape < 78) begin
      if ($urandom_range(1)) begin
        send_char($urandom_range(1) ? CH_LO_Z : CH_UP_Z);
        repeat ($urandom_range(6)) send_char(rand_hex());
      end
      send_char(CH_CR);
    end else if (shape < 83) begin
      send_char(cmd);
      repeat ($urandom_range(10)) send_char(rand_hex());
      send_char(CH_BEL);
    end else if (shape < 90) begin
      // truncated line or a length digit above eight
      send_char(cmd);
      if ($urandom_range(1)) begin
        repeat ($urandom_range(n_id + 8)) send_char(rand_hex());
      end else begin
        repeat (n_id) send_char(rand_hex());
        send_char(8'(CH_ZERO + $urandom_range(9, 22)));
        repeat ($urandom_range(16)) send_char(rand_hex());
      end
      send_char(CH_CR);
    end else begin
      repeat ($urandom_range(1, 40)) send_char(8'($urandom_range(255)));
      if ($urandom_range(1)) send_char(CH_CR);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  // Drive output stall: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted word with the oldest one due
  always @(posedge clk) begin : check_words
    can_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        report_mismatch("word with none due", '0, {62'b0, result_kind});
      end else begin
        want = words_due[0];
        words_due.delete(0);
        if (result_kind !== want.kind)
          report_mismatch("result_kind", 64'(want.kind), 64'(result_kind));
        if (remote_frame !== want.remote)
          report_mismatch("remote_frame", 64'(want.remote), 64'(remote_frame));
        if (extended_id !== want.ext)
          report_mismatch("extended_id", 64'(want.ext), 64'(extended_id));
        if (frame_id !== want.id)
          report_mismatch("frame_id", 64'(want.id), 64'(frame_id));
        if (data_length !== want.dlc)
          report_mismatch("data_length", 64'(want.dlc), 64'(data_length));
        if (payload !== want.data)
          report_mismatch("payload", want.data, payload);
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ascii_can_line_decoder_unit_tb: done, errors");
    $finish;
  end

  task automatic test_status_and_bell();
    send_char(CH_BEL);
    send_char(CH_CR);
    send_line("z");
    send_line("Zjunk!");
    send_text("t12");
    send_char(CH_BEL);
    send_line("");
  endtask

  task automatic test_frame_forms();
    send_line("t0000");
    send_line("t7FF80011223344556677");
    send_line("TFFFFFFFF8ffeeddccbbaa9988");
    send_line("T000000001A5");
    send_line("r1238");
    send_line("R1fffffff4");
    send_line("t1231AABBCC");
    send_line("tgz~2Gz!?");
    // bytes with the top bit set go through the lax conversion too
    send_char(CH_LO_T);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h00);
    send_char("1");
    send_char(8'h7F);
    send_char(8'h01);
    send_char(CH_CR);
  endtask

  task automatic test_dropped_lines();
    send_line("x123");
    send_line("t1239");
    send_line("t123:");
    send_line("t12");
    send_line("T1234567");
    send_line("t1232AAB");
    send_line("r123");
    send_line("t4561FF");
  endtask

  task automatic test_full_line();
    // exactly full line still decodes
    send_line("T1ABCDEF080123456789abcdefzzzzzz");
    // one more character than fits discards the line
    repeat (LINE_CHARS) send_char(CH_LO_T);
    send_char(CH_UP_A);
    send_line("");
    repeat (LINE_CHARS) send_char("1");
    send_char("2");
    send_line("t00111F");
  endtask

  task automatic test_output_hold_off();
    hold_req = 1'b1;
    repeat (6) send_line("t1232AABB");
    repeat (6) send_random_line();
    in_valid <= 1'b0;
    while (hold_req || hold_left != 0) @(posedge clk);
  endtask

  task automatic test_random_traffic();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) send_random_line();
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_status_and_bell();
    test_frame_forms();
    test_dropped_lines();
    test_full_line();
    test_output_hold_off();
    test_random_traffic();
    // drain, then allow for a walk over a line that gives no word
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("ascii_can_line_decoder_unit_tb: done, clean");
    end else begin
      $display("ascii_can_line_decoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
